// ===== rtl/pse_pkg.sv =====
// Shared constants and types for the postfix stack evaluator.
package pse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int SYM_W       = 8;
    localparam int DEPTH_W     = 5;
    localparam int STATUS_W    = 3;
    localparam int LIMIT_W     = 5;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ITER_W      = $clog2(DATA_W);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

    localparam logic [STATUS_W-1:0] ST_OK      = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_FULL    = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_EMPTY   = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_DIVZERO = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] ST_BADSYM  = STATUS_W'(4);
    localparam logic [STATUS_W-1:0] ST_HALTED  = STATUS_W'(5);

    localparam logic [SYM_W-1:0] CH_0     = 8'h30;
    localparam logic [SYM_W-1:0] CH_9     = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [SYM_W-1:0] CH_MOD   = 8'h25;

    typedef logic [DATA_W-1:0] t_word;

endpackage

// ===== rtl/postfix_stack_evaluator.sv =====
// Top level of the postfix stack evaluator: sequencer, stack RAM and shared divider.
//
// Each input item is one ASCII symbol on i_symbol. A digit pushes its value,
// and the operators + - * / % pop two entries and push the result. Each item
// gives exactly one result item: the top entry, the depth and a status code.
// The input channel is stalled while an item is in progress.
// A digit, a rejected symbol or any item after an error goes from acceptance
// straight to the final step, which loads the output register.
// Add, subtract and multiply read the operand, compute and write back, and a
// divide by zero is caught on the operand read. Divide and remainder run the
// restoring divider, which produces one quotient bit per cycle, then fix the
// signs before the write back.
// The stack sits in a 16 entry RAM with a registered read; the top entry is
// also held in a register, so an operator needs one RAM read.
// The depth limit is written over the configuration channel, which is always
// ready. Reset empties the stack, clears the error flag and sets the limit
// to 10. Any error freezes the stack until the next reset.
// If the receiver stalls, the result is held in the output register and the
// item in progress waits in its final step until that register frees up.
module postfix_stack_evaluator
    import pse_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [SYM_W-1:0]           i_symbol,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [DATA_W-1:0]   o_top_value,
    output logic [DEPTH_W-1:0]         o_stack_depth,
    output logic [STATUS_W-1:0]        o_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [LIMIT_W-1:0]         i_cfg_depth_limit
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_FIX    = 3'd3;
    localparam logic [2:0] S_WRITE  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [SYM_W-1:0]    r_sym, n_sym;
    t_word               r_top, n_top;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_halted, n_halted;
    logic [LIMIT_W-1:0]  r_limit, n_limit;
    logic [STATUS_W-1:0] r_status, n_status;
    t_word               r_res, n_res;
    t_word               r_quo, n_quo;
    t_word               r_rem, n_rem;
    t_word               r_div, n_div;
    logic                r_neg_q, n_neg_q;
    logic                r_neg_r, n_neg_r;
    logic [ITER_W-1:0]   r_iter, n_iter;

    logic                r_out_valid;
    t_word               r_out_top;
    logic [DEPTH_W-1:0]  r_out_depth;
    logic [STATUS_W-1:0] r_out_status;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    t_word               ram_wdata;
    t_word               ram_rdata;
    logic [CNT_W-1:0]    cnt_m2;
    logic                out_free;
    logic                is_digit;
    logic                is_op;
    logic                is_divmod;
    logic                full;
    logic [SYM_W-1:0]    digit;
    t_word               mul_lo;
    t_word               shifted;
    logic [DATA_W:0]     diff;
    t_word               op_a;

    assign cnt_m2    = r_count - CNT_W'(2);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign is_digit  = (i_symbol >= CH_0) && (i_symbol <= CH_9);
    assign is_op     = (i_symbol == CH_PLUS) || (i_symbol == CH_MINUS) ||
                       (i_symbol == CH_MUL) || (i_symbol == CH_DIV) || (i_symbol == CH_MOD);
    assign is_divmod = (r_sym == CH_DIV) || (r_sym == CH_MOD);
    assign full      = (r_count >= CNT_W'(r_limit)) || (r_count >= CNT_W'(STACK_DEPTH));
    assign digit     = i_symbol - CH_0;
    assign op_a      = ram_rdata;
    assign mul_lo    = DATA_W'(op_a * r_top);
    assign shifted   = {r_rem[DATA_W-2:0], r_quo[DATA_W-1]};
    assign diff      = {1'b0, shifted} - {1'b0, r_div};

    pse_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (cnt_m2[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_sym     = r_sym;
        n_top     = r_top;
        n_count   = r_count;
        n_halted  = r_halted;
        n_limit   = r_limit;
        n_status  = r_status;
        n_res     = r_res;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_div     = r_div;
        n_neg_q   = r_neg_q;
        n_neg_r   = r_neg_r;
        n_iter    = r_iter;
        ram_we    = 1'b0;
        ram_waddr = r_count[ADDR_W-1:0];
        ram_wdata = r_res;

        if (i_cfg_valid) begin
            n_limit = i_cfg_depth_limit;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sym    = i_symbol;
                    n_status = ST_OK;
                    n_state  = S_FINISH;
                    priority if (r_halted) begin
                        n_status = ST_HALTED;
                    end else if (is_digit) begin
                        if (full) begin
                            n_status = ST_FULL;
                            n_halted = 1'b1;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {{(DATA_W-SYM_W){1'b0}}, digit};
                            n_top     = {{(DATA_W-SYM_W){1'b0}}, digit};
                            n_count   = r_count + CNT_W'(1);
                        end
                    end else if (is_op) begin
                        if (r_count < CNT_W'(2)) begin
                            n_status = ST_EMPTY;
                            n_halted = 1'b1;
                        end else begin
                            n_state = S_READ;
                        end
                    end else begin
                        n_status = ST_BADSYM;
                        n_halted = 1'b1;
                    end
                end
            end
            S_READ: begin
                priority if (r_sym == CH_PLUS) begin
                    n_res   = op_a + r_top;
                    n_state = S_WRITE;
                end else if (r_sym == CH_MINUS) begin
                    n_res   = op_a - r_top;
                    n_state = S_WRITE;
                end else if (r_sym == CH_MUL) begin
                    n_res   = mul_lo;
                    n_state = S_WRITE;
                end else if (r_top == '0) begin
                    n_status = ST_DIVZERO;
                    n_halted = 1'b1;
                    n_state  = S_FINISH;
                end else begin
                    n_quo   = op_a[DATA_W-1] ? (DATA_W'(0) - op_a) : op_a;
                    n_div   = r_top[DATA_W-1] ? (DATA_W'(0) - r_top) : r_top;
                    n_rem   = '0;
                    n_neg_q = op_a[DATA_W-1] ^ r_top[DATA_W-1];
                    n_neg_r = op_a[DATA_W-1];
                    n_iter  = '1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!diff[DATA_W]) begin
                    n_rem = diff[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = shifted;
                    n_quo = {r_quo[DATA_W-2:0], 1'b0};
                end
                n_iter = r_iter - ITER_W'(1);
                if (r_iter == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if (r_sym == CH_DIV) begin
                    n_res = r_neg_q ? (DATA_W'(0) - r_quo) : r_quo;
                end else begin
                    n_res = r_neg_r ? (DATA_W'(0) - r_rem) : r_rem;
                end
                n_state = S_WRITE;
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_m2[ADDR_W-1:0];
                ram_wdata = r_res;
                n_top     = r_res;
                n_count   = r_count - CNT_W'(1);
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_halted <= n_halted;
            r_limit  <= n_limit;
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym    <= n_sym;
        r_top    <= n_top;
        r_status <= n_status;
        r_res    <= n_res;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_neg_q  <= n_neg_q;
        r_neg_r  <= n_neg_r;
        r_iter   <= n_iter;
        if (r_state == S_FINISH && out_free) begin
            r_out_top    <= (r_count == '0) ? '0 : r_top;
            r_out_depth  <= DEPTH_W'(r_count);
            r_out_status <= r_status;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_stack_depth = r_out_depth;
    assign o_status      = r_out_status;
    assign o_cfg_ready   = 1'b1;

endmodule

// ===== rtl/pse_ram.sv =====
// Generic single write port RAM with one registered read port.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pse_checker.sv =====
// Port level assertions for the postfix stack evaluator and their binding.
module pse_checker
    import pse_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [DATA_W-1:0] o_top_value,
    input logic [DEPTH_W-1:0]       o_stack_depth,
    input logic [STATUS_W-1:0]      o_status
);

    // An accepted item keeps the input channel stalled in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input channel not stalled after an accepted item");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_HALTED))
        else $error("status code out of range");

    a_empty_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stack_depth == '0) |-> (o_top_value == '0))
        else $error("empty stack reports a nonzero top value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_top_value) && $stable(o_stack_depth) && $stable(o_status)))
        else $error("stalled result item changed");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);
